@@ hdl/bcpe_pkg.sv @@
// shared constants and types for the bezier curve point evaluator
`default_nettype none

package bcpe_pkg;

   // default coordinate and curve parameter widths
   localparam int COORD_WIDTH_DEF     = 32;
   localparam int PARAM_FRAC_BITS_DEF = 16;

   // register stages in one interpolation level: subtract, multiply, add
   localparam int LEVEL_STAGES = 3;

   // curve degree selection codes
   localparam logic CURVE_QUADRATIC = 1'b0;
   localparam logic CURVE_CUBIC     = 1'b1;

   // per-stage load enables for one interpolation level
   typedef struct packed {
      logic sub_en;
      logic mul_en;
      logic add_en;
   } stage_en_type;

endpackage

`default_nettype wire

@@ hdl/bcpe_level.sv @@
// one de casteljau level: lanes of pipelined linear interpolation between neighbor points
`default_nettype none

module bcpe_level #(
   parameter int LANES           = 3,
   parameter int COORD_WIDTH     = bcpe_pkg::COORD_WIDTH_DEF,
   parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire bcpe_pkg::stage_en_type                 en,
   input  wire logic [LANES:0][COORD_WIDTH-1:0]        pts_in,
   input  wire logic [PARAM_FRAC_BITS:0]               t_in,
   output logic      [LANES-1:0][COORD_WIDTH-1:0]      pts_out,
   output logic      [PARAM_FRAC_BITS:0]               t_out
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = COORD_WIDTH + PARAM_FRAC_BITS + 3;

   // subtract stage
   logic [LANES-1:0][DW-1:0]          diff_ff, diff_in;
   logic [LANES-1:0][COORD_WIDTH-1:0] xa_ff;
   logic [PARAM_FRAC_BITS:0]          ta_ff;

   // multiply stage
   logic [LANES-1:0][PW-1:0]          prod_ff, prod_in;
   logic [LANES-1:0][COORD_WIDTH-1:0] xb_ff;
   logic [PARAM_FRAC_BITS:0]          tb_ff;

   // add stage
   logic [LANES-1:0][COORD_WIDTH-1:0] res_ff, res_in;
   logic [PARAM_FRAC_BITS:0]          tc_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff_in[i] = {pts_in[i+1][COORD_WIDTH-1], pts_in[i+1]}
                    - {pts_in[i][COORD_WIDTH-1], pts_in[i]};
         prod_in[i] = PW'($signed(diff_ff[i]) * $signed({1'b0, ta_ff}));
         // dropping the low fraction bits of the signed product is a floor
         res_in[i]  = xb_ff[i] + prod_ff[i][PARAM_FRAC_BITS +: COORD_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en.sub_en) begin
         diff_ff <= diff_in;
         xa_ff   <= pts_in[LANES-1:0];
         ta_ff   <= t_in;
      end
      if (en.mul_en) begin
         prod_ff <= prod_in;
         xb_ff   <= xa_ff;
         tb_ff   <= ta_ff;
      end
      if (en.add_en) begin
         res_ff <= res_in;
         tc_ff  <= tb_ff;
      end
   end

   assign pts_out = res_ff;
   assign t_out   = tc_ff;

endmodule

`default_nettype wire

@@ hdl/bezier_curve_point_evaluator.sv @@
// top level of the pipelined de casteljau bezier curve point evaluator
// pipeline: from req transaction to rsp_tvalid, one input stage, then three
//   interpolation levels of subtract, multiply and add stages
// throughput: one transaction per cycle; each stage advances when it is empty or its
//   successor advances, so bubbles collapse and a stall holds every stage in place
// reset: synchronous, clears all stage valid bits and sets curve_degree_mode to cubic
`default_nettype none

module bezier_curve_point_evaluator #(
   parameter int COORD_WIDTH     = bcpe_pkg::COORD_WIDTH_DEF,
   parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,

   // request stream
   input  wire logic req_tvalid,
   output logic      req_tready,
   // first_point, second_point, third_point, fourth_point, curve_param
   input  wire logic [((4*COORD_WIDTH+PARAM_FRAC_BITS+1+7)/8)*8-1:0] req_tdata,

   // response stream
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // curve_value
   output logic [((COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,

   // configuration write: curve_degree_mode
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [0:0] csr_data
);

   localparam int TW       = PARAM_FRAC_BITS + 1;
   localparam int OUT_BITS = ((COORD_WIDTH + 7) / 8) * 8;
   localparam int STAGES   = 1 + 3 * bcpe_pkg::LEVEL_STAGES;

   // stage indices of the first stage of each interpolation level
   localparam int L1_BASE = 1;
   localparam int L2_BASE = L1_BASE + bcpe_pkg::LEVEL_STAGES;
   localparam int L3_BASE = L2_BASE + bcpe_pkg::LEVEL_STAGES;

   // ---------------------------------------------------------------
   // configuration register, always ready
   // ---------------------------------------------------------------
   logic mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bcpe_pkg::CURVE_CUBIC;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data[0];
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow control: valid bit per stage, ready ripples back
   // ---------------------------------------------------------------
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   ready;

   always_comb begin
      ready[STAGES] = rsp_tready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in = {valid_ff[STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   // ---------------------------------------------------------------
   // input stage: unpack the transaction and clamp t to one
   // ---------------------------------------------------------------
   logic [3:0][COORD_WIDTH-1:0] pts0_ff, pts0_in;
   logic [TW-1:0]               t0_ff, t0_in;
   logic [TW-1:0]               t_raw;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pts0_in[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      end
      t_raw = req_tdata[4*COORD_WIDTH +: TW];
      // anything at or above one becomes exactly one
      t0_in = t_raw[PARAM_FRAC_BITS] ? {1'b1, {PARAM_FRAC_BITS{1'b0}}} : t_raw;
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         pts0_ff <= pts0_in;
         t0_ff   <= t0_in;
      end
   end

   // ---------------------------------------------------------------
   // three interpolation levels: 4 -> 3 -> 2 -> 1 points
   // ---------------------------------------------------------------
   bcpe_pkg::stage_en_type      l1_en, l2_en, l3_en;
   logic [2:0][COORD_WIDTH-1:0] l1_pts;
   logic [1:0][COORD_WIDTH-1:0] l2_pts;
   logic [0:0][COORD_WIDTH-1:0] l3_pts;
   logic [TW-1:0]               l1_t, l2_t, l3_t_in;

   assign l1_en = '{sub_en: ready[L1_BASE], mul_en: ready[L1_BASE+1], add_en: ready[L1_BASE+2]};
   assign l2_en = '{sub_en: ready[L2_BASE], mul_en: ready[L2_BASE+1], add_en: ready[L2_BASE+2]};
   assign l3_en = '{sub_en: ready[L3_BASE], mul_en: ready[L3_BASE+1], add_en: ready[L3_BASE+2]};

   // quadratic mode: t of zero makes the last level pass its first point, which
   // is already the quadratic curve over the first three control points
   assign l3_t_in = (mode_ff == bcpe_pkg::CURVE_CUBIC) ? l2_t : '0;

   bcpe_level #(
      .LANES           (3),
      .COORD_WIDTH     (COORD_WIDTH),
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
   ) u_level1 (
      .clock   (clock),
      .en      (l1_en),
      .pts_in  (pts0_ff),
      .t_in    (t0_ff),
      .pts_out (l1_pts),
      .t_out   (l1_t)
   );

   bcpe_level #(
      .LANES           (2),
      .COORD_WIDTH     (COORD_WIDTH),
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
   ) u_level2 (
      .clock   (clock),
      .en      (l2_en),
      .pts_in  (l1_pts),
      .t_in    (l1_t),
      .pts_out (l2_pts),
      .t_out   (l2_t)
   );

   bcpe_level #(
      .LANES           (1),
      .COORD_WIDTH     (COORD_WIDTH),
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
   ) u_level3 (
      .clock   (clock),
      .en      (l3_en),
      .pts_in  (l2_pts),
      .t_in    (l3_t_in),
      .pts_out (l3_pts),
      .t_out   ()
   );

   // last add stage register doubles as the output register
   assign rsp_tdata = OUT_BITS'(l3_pts[0]);

endmodule

`default_nettype wire
